[hdl/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Shared constants, operation codes and the structures between the
// controller and the timer cells.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int TIMER_COUNT = 32;
  localparam int TICK_WIDTH  = 32;
  localparam int IDX_W       = $clog2(TIMER_COUNT);
  localparam int SIG_W       = 7;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;

  localparam logic [1:0] NOTIFY_GIVEN = 2'd0;
  localparam logic [1:0] NOTIFY_NONE  = 2'd1;

  localparam logic       CFG_DEFAULT_SIGNAL = 1'b0;
  localparam logic       CFG_HIGHEST_SIGNAL = 1'b1;

  typedef struct packed {
    logic                  scan;
    logic                  shift;
    logic                  create;
    logic                  set;
    logic                  del;
    logic [SIG_W-1:0]      sig;
    logic [TICK_WIDTH-1:0] rem;
    logic [TICK_WIDTH-1:0] per;
  } cell_ctl_t;

  typedef struct packed {
    logic                  used;
    logic                  emit;
    logic                  tok;
    logic [SIG_W-1:0]      sig;
    logic [TICK_WIDTH-1:0] rem;
    logic [TICK_WIDTH-1:0] per;
  } cell_stat_t;

endpackage

[hdl/periodic_timer_bank.sv]
// ----------------------------------------------------------------------------
// Periodic timer bank
// A command item is registered, then its reply is loaded into the output
// registers when the output is free. Items are taken only while idle; a tick
// scan, paced by the token through the row of 32 timer cells, waits on stall.
// Reset: all slots free, tick count zero, registers at their defaults.
// ----------------------------------------------------------------------------
module periodic_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // timer_index, clock_select, notify_mode, signal_request, absolute,
  // start_ticks, period_ticks
  input  logic [87:0] s_axis_tdata,
  // op
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, out_timer, out_signal, out_remaining, out_period
  output logic [79:0] m_axis_tdata,
  // kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import ptb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMD  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SIG_W-1:0]      dflt_sig_r, high_sig_r;
  logic [TICK_WIDTH-1:0] tick_r;
  logic [IDX_W-1:0]      pos_r;
  logic [2:0]            op_r;
  logic [87:0]           cmd_r;

  logic                  ov_r, okind_r, olast_r;
  logic [1:0]            ostat_r;
  logic [IDX_W-1:0]      otimer_r;
  logic [SIG_W-1:0]      osig_r;
  logic [TICK_WIDTH-1:0] orem_r, oper_r;

  logic [IDX_W-1:0]      c_idx;
  logic [1:0]            c_clk, c_mode;
  logic [SIG_W-1:0]      c_req;
  logic                  c_abs;
  logic [TICK_WIDTH-1:0] c_start, c_per;

  cell_ctl_t             ctl;
  cell_stat_t            stat [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] used_vec, emit_vec, tok_vec, sel_vec, tok_chain;
  logic [SIG_W-1:0]      tok_sig;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_found;
  logic                  out_free, emit_here, advance, accept, start, is_last;
  logic                  load;
  logic                  n_kind, n_last;
  logic [1:0]            n_stat;
  logic [IDX_W-1:0]      n_timer;
  logic [SIG_W-1:0]      n_sig;
  logic [TICK_WIDTH-1:0] n_rem, n_per;

  assign c_idx   = cmd_r[4:0];
  assign c_clk   = cmd_r[6:5];
  assign c_mode  = cmd_r[8:7];
  assign c_req   = cmd_r[15:9];
  assign c_abs   = cmd_r[16];
  assign c_start = cmd_r[48:17];
  assign c_per   = cmd_r[80:49];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state_r == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && (s_axis_tuser == OP_TICK);
  assign out_free      = !ov_r || m_axis_tready;

  genvar g;
  generate
    for (g = 0; g < TIMER_COUNT; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign tok_chain[g] = start;
      end else begin : g_next
        assign tok_chain[g] = tok_vec[g-1];
      end
      ptb_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok_in (tok_chain[g]),
        .sel    (sel_vec[g]),
        .ctl    (ctl),
        .stat   (stat[g])
      );
      assign used_vec[g] = stat[g].used;
      assign emit_vec[g] = stat[g].emit;
      assign tok_vec[g]  = stat[g].tok;
    end
  endgenerate

  always_comb begin
    tok_sig    = '0;
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
      if (!used_vec[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (tok_vec[i]) begin
        tok_sig = tok_sig | stat[i].sig;
      end
    end
  end

  assign emit_here = |(tok_vec & emit_vec);
  assign advance   = !emit_here || out_free;
  assign is_last   = (((emit_vec >> pos_r) >> 1) == '0);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    sel_vec   = '0;
    load      = 1'b0;
    n_kind    = 1'b0;
    n_last    = 1'b1;
    n_stat    = ST_OK;
    n_timer   = '0;
    n_sig     = '0;
    n_rem     = '0;
    n_per     = '0;
    ctl.shift = start;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = start ? S_SCAN : S_CMD;
        end
      end
      S_CMD: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          unique case (op_r) inside
            OP_CREATE: begin
              if (c_clk > 2'd1) begin
                n_stat = ST_INVALID;
              end else if (!free_found) begin
                n_stat = ST_NO_SLOT;
              end else begin
                n_timer    = free_idx;
                ctl.create = 1'b1;
                sel_vec    = TIMER_COUNT'(1) << free_idx;
                if (c_mode == NOTIFY_NONE) begin
                  ctl.sig = '0;
                end else if (c_mode == NOTIFY_GIVEN && c_req != '0 &&
                             c_req <= high_sig_r) begin
                  ctl.sig = c_req;
                end else begin
                  ctl.sig = dflt_sig_r;
                end
              end
            end
            OP_SET, OP_GET, OP_DELETE: begin
              if (!used_vec[c_idx]) begin
                n_stat = ST_INVALID;
              end else begin
                sel_vec = TIMER_COUNT'(1) << c_idx;
                if (op_r != OP_DELETE) begin
                  n_rem = stat[c_idx].rem;
                  n_per = stat[c_idx].per;
                end
                if (op_r == OP_SET) begin
                  ctl.set = 1'b1;
                  ctl.per = c_per;
                  if (!c_abs) begin
                    ctl.rem = c_start;
                  end else if (c_start > tick_r) begin
                    ctl.rem = c_start - tick_r;
                  end else begin
                    ctl.rem = '0;
                  end
                end
                if (op_r == OP_DELETE) begin
                  ctl.del = 1'b1;
                end
              end
            end
            default: begin
              n_stat = ST_INVALID;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan  = 1'b1;
        ctl.shift = advance;
        if (emit_here && out_free) begin
          load    = 1'b1;
          n_kind  = 1'b1;
          n_timer = pos_r;
          n_sig   = tok_sig;
          n_last  = is_last;
        end
        if (advance && pos_r == IDX_W'(TIMER_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ov_r       <= 1'b0;
      tick_r     <= '0;
      pos_r      <= '0;
      dflt_sig_r <= SIG_W'(14);
      high_sig_r <= SIG_W'(32);
    end else begin
      state_r <= state_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (m_axis_tready) begin
        ov_r <= 1'b0;
      end
      if (start) begin
        tick_r <= tick_r + TICK_WIDTH'(1);
        pos_r  <= '0;
      end else if (state_r == S_SCAN && advance) begin
        pos_r <= pos_r + IDX_W'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DEFAULT_SIGNAL: dflt_sig_r <= cfg_data;
          CFG_HIGHEST_SIGNAL: high_sig_r <= cfg_data;
          default: ;
        endcase
      end
    end
    if (accept) begin
      op_r  <= s_axis_tuser;
      cmd_r <= s_axis_tdata;
    end
    if (load) begin
      okind_r  <= n_kind;
      olast_r  <= n_last;
      ostat_r  <= n_stat;
      otimer_r <= n_timer;
      osig_r   <= n_sig;
      orem_r   <= n_rem;
      oper_r   <= n_per;
    end
  end

  assign m_axis_tvalid = ov_r;
  assign m_axis_tuser  = okind_r;
  assign m_axis_tlast  = olast_r;
  assign m_axis_tdata  = {2'b00, oper_r, orem_r, osig_r, otimer_r, ostat_r};

endmodule

[hdl/ptb_cell.sv]
// ----------------------------------------------------------------------------
// Periodic timer bank cell
// Holds one timer slot and passes the scan token on to its neighbour.
// ----------------------------------------------------------------------------
module ptb_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_in,
  input  logic               sel,
  input  ptb_pkg::cell_ctl_t ctl,
  output ptb_pkg::cell_stat_t stat
);
  import ptb_pkg::*;

  logic                  used_r, used_nxt;
  logic                  tok_r, tok_nxt;
  logic [SIG_W-1:0]      sig_r, sig_nxt;
  logic [TICK_WIDTH-1:0] rem_r, rem_nxt;
  logic [TICK_WIDTH-1:0] per_r, per_nxt;

  always_comb begin
    used_nxt = used_r;
    tok_nxt  = tok_r;
    sig_nxt  = sig_r;
    rem_nxt  = rem_r;
    per_nxt  = per_r;
    if (ctl.shift) begin
      tok_nxt = tok_in;
    end
    if (ctl.scan && ctl.shift && tok_r && used_r && (rem_r != '0)) begin
      if (rem_r == TICK_WIDTH'(1)) begin
        rem_nxt = per_r;
      end else begin
        rem_nxt = rem_r - TICK_WIDTH'(1);
      end
    end
    if (sel && ctl.create) begin
      used_nxt = 1'b1;
      sig_nxt  = ctl.sig;
      rem_nxt  = '0;
      per_nxt  = '0;
    end
    if (sel && ctl.set) begin
      rem_nxt = ctl.rem;
      per_nxt = ctl.per;
    end
    if (sel && ctl.del) begin
      used_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
    sig_r <= sig_nxt;
    rem_r <= rem_nxt;
    per_r <= per_nxt;
  end

  always_comb begin
    stat.used = used_r;
    stat.emit = used_r && (rem_r == TICK_WIDTH'(1)) && (sig_r != '0);
    stat.tok  = tok_r;
    stat.sig  = sig_r;
    stat.rem  = rem_r;
    stat.per  = per_r;
  end

endmodule

[tb/ptb_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer bank monitor
// Watches the command, result and register channels of the timer bank,
// keeps its own model of the slots, the tick count and the registers, and
// compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ptb_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [87:0] in_data,
  input  logic [2:0]  in_op,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [79:0] out_data,
  input  logic        out_kind,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import ptb_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  timer;
    logic [6:0]  sig;
    logic [31:0] rem;
    logic [31:0] per;
    logic        last;
  } reply_t;

  reply_t      expected_replies[$];
  logic        used_q[TIMER_COUNT];
  logic [6:0]  sig_q[TIMER_COUNT];
  logic [31:0] rem_q[TIMER_COUNT];
  logic [31:0] per_q[TIMER_COUNT];
  logic [31:0] ticks;
  logic [6:0]  default_sig;
  logic [6:0]  highest_sig;

  task automatic push_reply(logic kind, logic [1:0] status, logic [4:0] timer,
                            logic [6:0] sig, logic [31:0] rem, logic [31:0] per,
                            logic last);
    reply_t r;
    r = '{kind, status, timer, sig, rem, per, last};
    expected_replies.push_back(r);
  endtask

  task automatic apply_command(logic [2:0] op, logic [87:0] d);
    logic [4:0]  idx;
    logic [1:0]  clk_sel;
    logic [1:0]  mode;
    logic [6:0]  req;
    logic        absolute;
    logic [31:0] start;
    logic [31:0] period;
    int          n;
    int          free_slot;
    idx      = d[4:0];
    clk_sel  = d[6:5];
    mode     = d[8:7];
    req      = d[15:9];
    absolute = d[16];
    start    = d[48:17];
    period   = d[80:49];
    n        = 0;
    free_slot = -1;
    case (op) inside
      OP_TICK: begin
        ticks = ticks + 1;
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (used_q[i] && rem_q[i] != 0) begin
            rem_q[i] = rem_q[i] - 1;
            if (rem_q[i] == 0) begin
              rem_q[i] = per_q[i];
              if (sig_q[i] != 0 && n < 32) begin
                push_reply(1'b1, ST_OK, i[4:0], sig_q[i], '0, '0, 1'b0);
                n++;
              end
            end
          end
        end
        if (n > 0) expected_replies[expected_replies.size()-1].last = 1'b1;
      end
      OP_CREATE: begin
        for (int i = TIMER_COUNT - 1; i >= 0; i--)
          if (!used_q[i]) free_slot = i;
        if (clk_sel > 1) begin
          push_reply(1'b0, ST_INVALID, '0, '0, '0, '0, 1'b1);
        end else if (free_slot < 0) begin
          push_reply(1'b0, ST_NO_SLOT, '0, '0, '0, '0, 1'b1);
        end else begin
          used_q[free_slot] = 1'b1;
          if (mode == NOTIFY_NONE) sig_q[free_slot] = '0;
          else if (mode == NOTIFY_GIVEN && req != 0 && req <= highest_sig)
            sig_q[free_slot] = req;
          else sig_q[free_slot] = default_sig;
          rem_q[free_slot] = '0;
          per_q[free_slot] = '0;
          push_reply(1'b0, ST_OK, free_slot[4:0], '0, '0, '0, 1'b1);
        end
      end
      OP_SET, OP_GET, OP_DELETE: begin
        if (!used_q[idx]) begin
          push_reply(1'b0, ST_INVALID, '0, '0, '0, '0, 1'b1);
        end else if (op == OP_SET) begin
          push_reply(1'b0, ST_OK, '0, '0, rem_q[idx], per_q[idx], 1'b1);
          if (absolute) rem_q[idx] = (start > ticks) ? start - ticks : '0;
          else rem_q[idx] = start;
          per_q[idx] = period;
        end else if (op == OP_GET) begin
          push_reply(1'b0, ST_OK, '0, '0, rem_q[idx], per_q[idx], 1'b1);
        end else begin
          used_q[idx] = 1'b0;
          push_reply(1'b0, ST_OK, '0, '0, '0, '0, 1'b1);
        end
      end
      default: push_reply(1'b0, ST_INVALID, '0, '0, '0, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      expected_replies.delete();
      for (int i = 0; i < TIMER_COUNT; i++) begin
        used_q[i] = 1'b0;
        sig_q[i]  = '0;
        rem_q[i]  = '0;
        per_q[i]  = '0;
      end
      ticks       = '0;
      default_sig = 7'd14;
      highest_sig = 7'd32;
      fail_count  = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_kind, out_data[1:0], out_data[6:2], out_data[13:7],
                out_data[45:14], out_data[77:46], out_last};
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result item: kind %0d status %0d timer %0d sig %0d",
                     got.kind, got.status, got.timer, got.sig);
        end else begin
          want = expected_replies.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"Mismatch: expected kind %0d st %0d tmr %0d sig %0d rem %h per %h",
                        " last %0d, got kind %0d st %0d tmr %0d sig %0d rem %h per %h",
                        " last %0d"},
                       want.kind, want.status, want.timer, want.sig, want.rem,
                       want.per, want.last, got.kind, got.status, got.timer,
                       got.sig, got.rem, got.per, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEFAULT_SIGNAL) default_sig = cfg_data;
        else highest_sig = cfg_data;
      end
      if (in_valid && in_ready) apply_command(in_op, in_data);
    end
    pending = expected_replies.size();
  end

endmodule

[tb/periodic_timer_bank_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer bank testbench
// Drives directed and random timer commands and register writes through
// three phases of sender and receiver idling, and reports the verdict
// from the monitor's failure and pending counts.
// ----------------------------------------------------------------------------
module periodic_timer_bank_tb;
  import ptb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  int          fail_count;
  int          pending;
  int          send_gap_pct;
  int          stall_pct;
  int          quiet_cycles;

  periodic_timer_bank dut (.*);

  ptb_monitor monitor (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_op(s_axis_tuser),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_kind(m_axis_tuser), .out_last(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(logic [2:0] op, logic [4:0] idx, logic [1:0] clk_sel,
                              logic [1:0] mode, logic [6:0] req, logic absolute,
                              logic [31:0] start, logic [31:0] period);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, period, start, absolute, req, mode, clk_sel, idx};
    #1;
    while (!s_axis_tready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  task automatic write_register(logic index, logic [6:0] value);
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0: pick_count = '0;
      1: pick_count = 32'hFFFF_FFFF;
      2: pick_count = $urandom();
      default: pick_count = $urandom_range(1, 6);
    endcase
  endfunction

  task automatic random_command();
    int          pick;
    logic [2:0]  op;
    logic [4:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_TICK;
    else if (pick < 62) op = OP_CREATE;
    else if (pick < 80) op = OP_SET;
    else if (pick < 88) op = OP_GET;
    else if (pick < 97) op = OP_DELETE;
    else op = 3'($urandom_range(5, 7));
    idx = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 9));
    send_command(op, idx, ($urandom_range(0, 9) == 0) ? 2'($urandom()) : 2'($urandom_range(0, 1)),
                 2'($urandom()), 7'($urandom()), 1'($urandom()), pick_count(), pick_count());
  endtask

  initial begin
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = 1'b0;
    cfg_data      = '0;
    send_gap_pct  = 7;
    stall_pct     = 67;
    quiet_cycles  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_command(OP_CREATE, 0, 2, 0, 5, 0, 0, 0);
    send_command(OP_CREATE, 0, 3, 0, 5, 0, 0, 0);
    send_command(OP_CREATE, 0, 0, 0, 5, 0, 0, 0);
    send_command(OP_CREATE, 0, 1, 1, 9, 0, 0, 0);
    send_command(OP_CREATE, 0, 0, 2, 9, 0, 0, 0);
    send_command(OP_CREATE, 0, 1, 3, 9, 0, 0, 0);
    send_command(OP_CREATE, 0, 0, 0, 0, 0, 0, 0);
    send_command(OP_CREATE, 0, 0, 0, 127, 0, 0, 0);
    send_command(OP_CREATE, 0, 0, 0, 32, 0, 0, 0);
    send_command(OP_CREATE, 0, 0, 0, 33, 0, 0, 0);
    send_command(OP_SET, 0, 0, 0, 0, 0, 2, 3);
    send_command(OP_SET, 1, 0, 0, 0, 0, 1, 1);
    send_command(OP_SET, 2, 0, 0, 0, 1, 3, 0);
    send_command(OP_SET, 3, 0, 0, 0, 1, 0, 0);
    send_command(OP_GET, 0, 0, 0, 0, 0, 0, 0);
    repeat (3) send_command(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_command(OP_GET, 20, 0, 0, 0, 0, 0, 0);
    send_command(3'd5, 0, 0, 0, 0, 0, 0, 0);
    send_command(3'd7, 31, 3, 3, 127, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_DELETE, 3, 0, 0, 0, 0, 0, 0);
    send_command(OP_DELETE, 3, 0, 0, 0, 0, 0, 0);
    send_command(OP_SET, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_GET, 0, 0, 0, 0, 0, 0, 0);
    drain_results();

    write_register(CFG_DEFAULT_SIGNAL, 7'd64);
    write_register(CFG_HIGHEST_SIGNAL, 7'd64);
    repeat (25) send_command(OP_CREATE, 0, 0, 2'($urandom()), 7'($urandom()), 0, 0, 0);
    repeat (85) random_command();
    drain_results();

    send_gap_pct = 67;
    stall_pct    = 7;
    write_register(CFG_DEFAULT_SIGNAL, 7'd0);
    write_register(CFG_HIGHEST_SIGNAL, 7'd1);
    repeat (85) random_command();
    drain_results();

    send_gap_pct = 0;
    stall_pct    = 0;
    write_register(CFG_DEFAULT_SIGNAL, 7'd33);
    write_register(CFG_HIGHEST_SIGNAL, 7'd127);
    repeat (85) random_command();
    drain_results();

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[periodic_timer_bank.f]
hdl/ptb_pkg.sv
hdl/ptb_cell.sv
hdl/periodic_timer_bank.sv
tb/ptb_monitor.sv
tb/periodic_timer_bank_tb.sv
